// ----- design/tccw_pkg.sv -----
`default_nettype none

package tccw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;

  // Derived widths
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int COLX_W = $clog2(COLUMNS + 8);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ROWX_W = $clog2(ROWS + 1);
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CNT_W  = $clog2(CELL_COUNT + 1);

  // Field widths
  localparam int FUNC_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 4;
  localparam int INDEX_W = 11;
  localparam int LOC_W   = 11;
  localparam int CELL_W  = 16;
  localparam int ATTR_W  = 8;

  // Configuration port
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_TEXT_ATTR  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_BLANK_ATTR = 1'b1;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_BLANK = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd3;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_LAST  = 8'h7F;

  localparam int                 TAB_STEP   = 8;
  localparam logic [COLOR_W-1:0] BLANK_FG   = 4'hF;
  localparam logic [ATTR_W-1:0]  ATTR_RESET = 8'h0F;

  // Frame store sweep mode
  typedef enum logic [1:0] {
    SWEEP_NONE,
    SWEEP_COPY,
    SWEEP_FILL
  } sweep_e;

  // Controller to datapath
  typedef struct packed {
    logic   load_item;
    logic   commit;
    logic   cnt_clr;
    logic   cnt_inc;
    logic   fill_load;
    sweep_e sweep;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear;
    logic scroll;
    logic copy_end;
    logic fill_end;
  } sts_t;

endpackage

`default_nettype wire

// ----- design/tccw_ram.sv -----
`default_nettype none

module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, hold data when idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- design/tccw_ctrl.sv -----
`default_nettype none

module tccw_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire tccw_pkg::sts_t sts_i,
  output tccw_pkg::cmd_t     cmd_o
);

  import tccw_pkg::*;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_IDLE,
    ST_EXEC,
    ST_COPY
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Sequence one item at a time, then any sweep over the frame store
  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit    = 1'b1;
          cmd_o.fill_load = 1'b1;
          cmd_o.cnt_clr   = 1'b1;
          out_valid_d     = 1'b1;
          if (sts_i.clear) begin
            state_d = ST_FILL;
          end else if (sts_i.scroll) begin
            state_d = ST_COPY;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_COPY: begin
        cmd_o.sweep = SWEEP_COPY;
        if (sts_i.copy_end) begin
          state_d = ST_FILL;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      ST_FILL: begin
        cmd_o.sweep = SWEEP_FILL;
        if (sts_i.fill_end) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
    endcase
  end

  // State and output valid; reset starts with a blanking pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- design/tccw_dpath.sv -----
`default_nettype none

module tccw_dpath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire tccw_pkg::cmd_t                  cmd_i,
  output tccw_pkg::sts_t                       sts_o,
  input  wire logic [tccw_pkg::FUNC_W-1:0]     func_i,
  input  wire logic [tccw_pkg::CHAR_W-1:0]     char_code_i,
  input  wire logic [tccw_pkg::COLOR_W-1:0]    color_i,
  input  wire logic [tccw_pkg::INDEX_W-1:0]    cell_index_i,
  output logic      [tccw_pkg::LOC_W-1:0]      cursor_location_o,
  output logic      [tccw_pkg::CELL_W-1:0]     cell_data_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [tccw_pkg::APB_AW-1:0]     paddr,
  input  wire logic [tccw_pkg::APB_DW-1:0]     pwdata,
  output logic      [tccw_pkg::APB_DW-1:0]     prdata
);

  import tccw_pkg::*;

  // Item registers
  logic [FUNC_W-1:0]  func_q;
  logic [CHAR_W-1:0]  code_q;
  logic [COLOR_W-1:0] color_q;
  logic               read_ok_q;

  // Cursor, counters and configuration
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [ATTR_W-1:0] text_attr_q;
  logic [ATTR_W-1:0] blank_attr_q;
  logic [CELL_W-1:0] fill_cell_q;

  // Result registers
  logic [LOC_W-1:0]  loc_q;
  logic [CELL_W-1:0] data_q;

  // Cursor update
  logic [COLX_W-1:0] col_ext, col_n;
  logic [ROWX_W-1:0] row_n;
  logic [COL_W-1:0]  col_f;
  logic [ROW_W-1:0]  row_f;
  logic              row_inc, wrap, scroll, wr_en, printable;
  logic [CELL_W-1:0] wr_cell;
  logic [ADDR_W-1:0] cur_addr;
  logic [LOC_W-1:0]  loc_n;

  // Frame store ports
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  logic [REG_IDX_W-1:0] reg_idx;

  // Work out the cell to write and where the cursor goes
  always_comb begin
    col_ext   = COLX_W'(col_q);
    col_n     = col_ext;
    row_inc   = 1'b0;
    wr_en     = 1'b0;
    wr_cell   = {text_attr_q, code_q};
    printable = (code_q >= CHAR_SPACE) && (code_q <= CHAR_LAST);
    unique case (func_q)
      FUNC_PUT: begin
        unique case (code_q)
          CHAR_BS: begin
            if (col_q != '0) begin
              col_n = col_ext - COLX_W'(1);
            end
          end
          CHAR_TAB: col_n = (col_ext + COLX_W'(TAB_STEP)) & ~COLX_W'(TAB_STEP - 1);
          CHAR_CR:  col_n = '0;
          CHAR_LF: begin
            col_n   = '0;
            row_inc = 1'b1;
          end
          default: begin
            if (printable) begin
              wr_en = 1'b1;
              col_n = col_ext + COLX_W'(1);
            end
          end
        endcase
      end
      FUNC_BLANK: begin
        wr_en   = 1'b1;
        wr_cell = {color_q, BLANK_FG, CHAR_SPACE};
        col_n   = col_ext + COLX_W'(1);
      end
      FUNC_CLEAR: col_n = '0;
      default: ;
    endcase
    wrap   = (col_n >= COLX_W'(COLUMNS));
    col_f  = wrap ? '0 : col_n[COL_W-1:0];
    row_n  = ROWX_W'(row_q) + ROWX_W'(row_inc || wrap);
    scroll = (row_n >= ROWX_W'(ROWS));
    if (func_q == FUNC_CLEAR) begin
      row_f = '0;
    end else if (scroll) begin
      row_f = ROW_W'(ROWS - 1);
    end else begin
      row_f = row_n[ROW_W-1:0];
    end
  end

  assign cur_addr = ADDR_W'(int'(row_q) * COLUMNS + int'(col_q));
  assign loc_n    = LOC_W'(int'(row_f) * COLUMNS + int'(col_f));

  // Steer the frame store ports between item, scroll copy and fill
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = wr_cell;
    unique case (cmd_i.sweep)
      SWEEP_COPY: begin
        ram_we    = (cnt_q != '0);
        ram_waddr = ADDR_W'(cnt_q - CNT_W'(1));
        ram_wdata = ram_rdata;
      end
      SWEEP_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(cnt_q);
        ram_wdata = fill_cell_q;
      end
      default: ram_we = cmd_i.commit && wr_en;
    endcase
    ram_re = cmd_i.load_item
          || ((cmd_i.sweep == SWEEP_COPY) && (cnt_q < CNT_W'(COPY_COUNT)));
    ram_raddr = cmd_i.load_item ? ADDR_W'(cell_index_i) : ADDR_W'(cnt_q + CNT_W'(COLUMNS));
  end

  tccw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Status back to the controller
  assign sts_o.clear    = (func_q == FUNC_CLEAR);
  assign sts_o.scroll   = scroll;
  assign sts_o.copy_end = (cnt_q == CNT_W'(COPY_COUNT));
  assign sts_o.fill_end = (cnt_q == CNT_W'(CELL_COUNT - 1));

  assign reg_idx = paddr[APB_AW-1:2];

  // Control state: cursor, sweep counter, fill cell, attributes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      cnt_q        <= '0;
      text_attr_q  <= ATTR_RESET;
      blank_attr_q <= ATTR_RESET;
      fill_cell_q  <= {ATTR_RESET, CHAR_SPACE};
    end else begin
      if (cmd_i.commit) begin
        col_q <= col_f;
        row_q <= row_f;
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.fill_load) begin
        fill_cell_q <= {blank_attr_q, CHAR_SPACE};
      end
      if (psel && penable && pwrite) begin
        unique case (reg_idx)
          REG_TEXT_ATTR:  text_attr_q  <= pwdata[ATTR_W-1:0];
          REG_BLANK_ATTR: blank_attr_q <= pwdata[ATTR_W-1:0];
        endcase
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      func_q    <= func_i;
      code_q    <= char_code_i;
      color_q   <= color_i;
      read_ok_q <= (int'(cell_index_i) < CELL_COUNT);
    end
    if (cmd_i.commit) begin
      loc_q  <= loc_n;
      data_q <= ((func_q == FUNC_READ) && read_ok_q) ? ram_rdata : '0;
    end
  end

  // Register read back
  always_comb begin
    unique case (reg_idx)
      REG_TEXT_ATTR:  prdata = APB_DW'(text_attr_q);
      REG_BLANK_ATTR: prdata = APB_DW'(blank_attr_q);
    endcase
  end

  assign cursor_location_o = loc_q;
  assign cell_data_o       = data_q;

endmodule

`default_nettype wire

// ----- design/text_console_cell_writer_top.sv -----
`default_nettype none

// Text console engine with an 80x25 frame store of 16-bit cells (attribute in the
// high byte, character in the low byte) and a cursor. Each item (put character,
// put coloured blank, clear, read cell) returns one result carrying the cursor
// location and, for a read, the cell. An ordinary item is first taken in (and the
// frame store read launched); then the cell is written, the cursor moved and the
// output register loaded, a step that stalls while an earlier result still waits;
// a waiting result does not block the next transfer. A clear then blanks the whole
// store, and a scroll copies rows up and blanks the bottom row, both through the
// single write port of the frame store; no item is taken meanwhile. After reset
// the same blanking pass runs before the first item is taken, while register
// writes are taken throughout. Registers: text attribute at 0x0, blank attribute
// at 0x4, both 0x0F after reset.
module text_console_cell_writer_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [tccw_pkg::FUNC_W-1:0]     func_i,
  input  wire logic [tccw_pkg::CHAR_W-1:0]     char_code_i,
  input  wire logic [tccw_pkg::COLOR_W-1:0]    color_i,
  input  wire logic [tccw_pkg::INDEX_W-1:0]    cell_index_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [tccw_pkg::LOC_W-1:0]      cursor_location_o,
  output logic      [tccw_pkg::CELL_W-1:0]     cell_data_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [tccw_pkg::APB_AW-1:0]     paddr,
  input  wire logic [tccw_pkg::APB_DW-1:0]     pwdata,
  output logic      [tccw_pkg::APB_DW-1:0]     prdata,
  output logic                                 pready
);

  import tccw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tccw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tccw_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .func_i            (func_i),
    .char_code_i       (char_code_i),
    .color_i           (color_i),
    .cell_index_i      (cell_index_i),
    .cursor_location_o (cursor_location_o),
    .cell_data_o       (cell_data_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata)
  );

  // Register writes complete without wait states
  assign pready = 1'b1;

endmodule

`default_nettype wire

// ----- design/tccw_checker.sv -----
`default_nettype none

module tccw_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic [tccw_pkg::FUNC_W-1:0] func_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [tccw_pkg::LOC_W-1:0]  cursor_location_o,
  input wire logic [tccw_pkg::CELL_W-1:0] cell_data_o
);

  import tccw_pkg::*;

  // One item in flight: no transfer in the cycle after one is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  // With the output free, a result follows the transfer via the execute state and the output register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> ##1 out_valid_o)
    else $error("result missing two cycles after transfer");

  // A clear homes the cursor
  a_clear_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o && (func_i == FUNC_CLEAR)
      |=> ##1 (cursor_location_o == '0))
    else $error("clear did not home the cursor");

  // Cursor stays on the screen
  a_loc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(cursor_location_o) < CELL_COUNT))
    else $error("cursor location off screen");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i
      |=> out_valid_o && $stable(cursor_location_o) && $stable(cell_data_o))
    else $error("stalled result changed");

endmodule

bind text_console_cell_writer_top tccw_checker u_checker (.*);

`default_nettype wire
